>>> rtl/utf8d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

    localparam int BYTE_W     = 8;
    localparam int CP_W       = 21;
    localparam int REM_W      = 2;
    localparam int M_TDATA_W  = 24;

    // lead and continuation byte classes
    localparam logic [BYTE_W-1:0] MASK_ASCII = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
    localparam logic [BYTE_W-1:0] PAT_CONT   = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
    localparam logic [BYTE_W-1:0] PAT_LEAD4  = 8'hF0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
    localparam logic [BYTE_W-1:0] PAT_LEAD3  = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
    localparam logic [BYTE_W-1:0] PAT_LEAD2  = 8'hC0;

    localparam logic [BYTE_W-1:0] BITS_LEAD4 = 8'h07;
    localparam logic [BYTE_W-1:0] BITS_LEAD3 = 8'h0F;
    localparam logic [BYTE_W-1:0] BITS_LEAD2 = 8'h1F;
    localparam logic [BYTE_W-1:0] BITS_CONT  = 8'h3F;

    localparam logic [REM_W-1:0] REM_NONE  = 2'd0;
    localparam logic [REM_W-1:0] REM_ONE   = 2'd1;
    localparam logic [REM_W-1:0] REM_TWO   = 2'd2;
    localparam logic [REM_W-1:0] REM_THREE = 2'd3;

    typedef struct packed {
        logic [REM_W-1:0] remaining;
        logic [CP_W-1:0]  partial;
    } t_dec_state;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
        logic            error;
    } t_dec_result;

endpackage

`default_nettype wire

>>> rtl/utf8d_step.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8d_step (
    input  wire logic                       i_enabled,
    input  wire logic [utf8d_pkg::BYTE_W-1:0] i_byte,
    input  wire utf8d_pkg::t_dec_state      i_state,
    output utf8d_pkg::t_dec_state           o_state,
    output utf8d_pkg::t_dec_result          o_result
);
    import utf8d_pkg::*;

    logic [CP_W-1:0]  w_byte_cp;
    logic [CP_W-1:0]  w_shifted;
    logic [REM_W-1:0] w_rem_dec;

    assign w_byte_cp = {{(CP_W-BYTE_W){1'b0}}, i_byte};
    assign w_shifted = {i_state.partial[CP_W-7:0], i_byte[5:0]};
    assign w_rem_dec = i_state.remaining - REM_ONE;

    always_comb begin
        o_state  = '{remaining: REM_NONE, partial: '0};
        o_result = '{valid: 1'b0, code_point: '0, error: 1'b0};
        priority if (!i_enabled) begin
            o_result = '{valid: 1'b1, code_point: w_byte_cp, error: 1'b0};
        end else if (i_state.remaining != REM_NONE) begin
            if ((i_byte & MASK_CONT) != PAT_CONT) begin
                // broken sequence: byte consumed, sequence dropped
                o_result = '{valid: 1'b1, code_point: '0, error: 1'b1};
            end else if (w_rem_dec == REM_NONE) begin
                o_result = '{valid: 1'b1, code_point: w_shifted, error: 1'b0};
            end else begin
                o_state = '{remaining: w_rem_dec, partial: w_shifted};
            end
        end else if ((i_byte & MASK_ASCII) == '0) begin
            o_result = '{valid: 1'b1, code_point: w_byte_cp, error: 1'b0};
        end else if ((i_byte & MASK_LEAD4) == PAT_LEAD4) begin
            o_state = '{remaining: REM_THREE,
                        partial: {{(CP_W-BYTE_W){1'b0}}, i_byte & BITS_LEAD4}};
        end else if ((i_byte & MASK_LEAD3) == PAT_LEAD3) begin
            o_state = '{remaining: REM_TWO,
                        partial: {{(CP_W-BYTE_W){1'b0}}, i_byte & BITS_LEAD3}};
        end else if ((i_byte & MASK_LEAD2) == PAT_LEAD2) begin
            o_state = '{remaining: REM_ONE,
                        partial: {{(CP_W-BYTE_W){1'b0}}, i_byte & BITS_LEAD2}};
        end else begin
            // stray continuation or lead byte 0xF8 and up
            o_result = '{valid: 1'b1, code_point: '0, error: 1'b1};
        end
    end

endmodule

`default_nettype wire

>>> rtl/utf8_code_point_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 code point decoder. Takes one byte per beat on the slave stream and
// gives one code point per completed sequence on the master stream; lead and
// middle continuation bytes give no beat, and a malformed byte gives an error
// beat (tuser high, code point zero) and drops the open sequence. Throughput
// is one byte per clock while the input does not stall: a byte is registered
// at the input, decoded against the sequence state in a single step, and the
// result registered at the output, so a result is offered on the master
// stream once its last byte has passed the input and output registers.
// The input stalls only when a byte that produces a result meets a full
// output register that is not being drained. With i_cfg_wr_data low at a
// write the block passes each byte through as a code point (decoding is on
// after reset); write it only while the block is idle.
module utf8_code_point_decoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data,   // utf8_enabled
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] byte_in
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,    // [20:0] code_point, [23:21] zero
    output logic             m_axis_tuser     // [0] error
);
    import utf8d_pkg::*;

    logic              r_enabled;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    t_dec_state        r_state;
    logic              r_out_valid;
    logic [CP_W-1:0]   r_out_cp;
    logic              r_out_err;

    t_dec_state  n_state;
    t_dec_result w_result;
    logic        w_advance;
    logic        w_in_fire;

    utf8d_step u_step (
        .i_enabled (r_enabled),
        .i_byte    (r_in_byte),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_result  (w_result)
    );

    // held byte moves on unless it has a result and the output is blocked
    assign w_advance     = r_in_valid && (!w_result.valid || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b1;
            r_in_valid  <= 1'b0;
            r_state     <= '{remaining: REM_NONE, partial: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_enabled <= i_cfg_wr_data;
            end
            if (w_in_fire) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_state <= n_state;
            end
            if (w_advance && w_result.valid) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_advance && w_result.valid) begin
            r_out_cp  <= w_result.code_point;
            r_out_err <= w_result.error;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-CP_W){1'b0}}, r_out_cp};
    assign m_axis_tuser  = r_out_err;

endmodule

`default_nettype wire

>>> rtl/utf8d_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module utf8d_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // an error beat never carries a code point
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 24'd0)
        else $error("error beat with nonzero code point");

    // padding above the code point stays clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:21] == 3'd0)
        else $error("tdata padding not zero");

    // with the output empty, the input side never stalls
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // first cycle out of reset shows no beat
    a_rst_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

endmodule

bind utf8_code_point_decoder_core utf8d_checker u_utf8d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> test/utf8_code_point_decoder_checker.sv
`timescale 1ns / 1ps

module utf8_code_point_decoder_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data,
    input  wire logic        i_byte_valid,
    input  wire logic        i_byte_ready,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_cp_valid,
    input  wire logic        i_cp_ready,
    input  wire logic [23:0] i_cp_data,
    input  wire logic        i_cp_error,
    output int               o_mismatches,
    output int               o_outstanding
);
    import utf8d_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            error;
    } t_cp_beat;

    t_cp_beat expected_code_points[$];

    logic              dec_enabled;
    logic [REM_W-1:0]  dec_remaining;
    logic [CP_W-1:0]   dec_partial;

    task automatic decode_utf8_byte(input logic [7:0] b, output bit has_cp,
                                    output t_cp_beat res);
        has_cp = 1'b0;
        res    = '0;
        if (!dec_enabled) begin
            // pass-through also drops any open sequence
            dec_remaining   = REM_NONE;
            dec_partial     = '0;
            has_cp          = 1'b1;
            res.code_point  = CP_W'(b);
        end else if (dec_remaining != REM_NONE) begin
            if ((b & MASK_CONT) != PAT_CONT) begin
                // broken sequence: byte is consumed, not restarted as a lead
                dec_remaining = REM_NONE;
                dec_partial   = '0;
                has_cp        = 1'b1;
                res.error     = 1'b1;
            end else begin
                dec_partial   = {dec_partial[CP_W-7:0], b[5:0]};
                dec_remaining = dec_remaining - REM_ONE;
                if (dec_remaining == REM_NONE) begin
                    has_cp         = 1'b1;
                    res.code_point = dec_partial;
                    dec_partial    = '0;
                end
            end
        end else if ((b & MASK_ASCII) == 8'h00) begin
            has_cp         = 1'b1;
            res.code_point = CP_W'(b);
        end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
            dec_partial   = CP_W'(b & BITS_LEAD4);
            dec_remaining = REM_THREE;
        end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
            dec_partial   = CP_W'(b & BITS_LEAD3);
            dec_remaining = REM_TWO;
        end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
            dec_partial   = CP_W'(b & BITS_LEAD2);
            dec_remaining = REM_ONE;
        end else begin
            // stray continuation or lead of 0xF8 and up
            dec_remaining = REM_NONE;
            dec_partial   = '0;
            has_cp        = 1'b1;
            res.error     = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_cp_beat got;
        t_cp_beat want;
        t_cp_beat res;
        bit       has_cp;
        if (!i_rst_n) begin
            dec_enabled   = 1'b1;
            dec_remaining = REM_NONE;
            dec_partial   = '0;
            expected_code_points.delete();
        end else begin
            if (i_cp_valid && i_cp_ready) begin
                got.code_point = i_cp_data[CP_W-1:0];
                got.error      = i_cp_error;
                if (expected_code_points.size() == 0) begin
                    $error("result beat with nothing expected: code_point %0h error %0b",
                           got.code_point, got.error);
                    o_mismatches++;
                end else begin
                    want = expected_code_points.pop_front();
                    if (got.code_point !== want.code_point) begin
                        $error("code_point mismatch: expected %0h, actual %0h",
                               want.code_point, got.code_point);
                        o_mismatches++;
                    end
                    if (got.error !== want.error) begin
                        $error("error mismatch: expected %0b, actual %0b",
                               want.error, got.error);
                        o_mismatches++;
                    end
                end
            end
            if (i_byte_valid && i_byte_ready) begin
                decode_utf8_byte(i_byte, has_cp, res);
                if (has_cp)
                    expected_code_points.push_back(res);
            end
            if (i_cfg_wr_en)
                dec_enabled = i_cfg_wr_data;
        end
        o_outstanding = expected_code_points.size();
    end

endmodule

>>> test/utf8_code_point_decoder_core_tb.sv
`timescale 1ns / 1ps

module utf8_code_point_decoder_core_tb;

    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 4;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    int fail_count;
    int results_pending;
    bit sender_gaps_on = 1'b1;
    bit sink_hold_req  = 1'b0;

    always #6 i_clk = ~i_clk;

    utf8_code_point_decoder_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    utf8_code_point_decoder_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte_valid  (s_axis_tvalid),
        .i_byte_ready  (s_axis_tready),
        .i_byte        (s_axis_tdata),
        .i_cp_valid    (m_axis_tvalid),
        .i_cp_ready    (m_axis_tready),
        .i_cp_data     (m_axis_tdata),
        .i_cp_error    (m_axis_tuser),
        .o_mismatches  (fail_count),
        .o_outstanding (results_pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!sender_gaps_on || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Returns right after the accepting edge; the next call or wait_idle
    // decides what tvalid does at the following falling edge.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        // a lead byte leaves nothing pending but may still be in flight
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_decode_enable(input logic en);
        wait_idle();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = en;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    // Mostly well-formed characters, some cut-off sequences and raw noise.
    task automatic send_random_text(input int n_bytes, input bit decoding);
        int sent;
        int r;
        int len;
        int n_cont;
        logic [7:0] b;
        sent = 0;
        while (sent < n_bytes) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 199) == 0)
                wait_idle();
            if (!decoding || r >= 90) begin
                send_byte(8'($urandom_range(0, 255)));
                sent++;
            end else begin
                len = $urandom_range(1, 4);
                case (len)
                    1: b = 8'($urandom_range(8'h00, 8'h7F));
                    2: b = 8'hC0 | 8'($urandom_range(0, 8'h1F));
                    3: b = 8'hE0 | 8'($urandom_range(0, 8'h0F));
                    default: b = 8'hF0 | 8'($urandom_range(0, 8'h07));
                endcase
                send_byte(b);
                sent++;
                n_cont = (r < 80 || len == 1) ? len - 1 : $urandom_range(0, len - 2);
                repeat (n_cont) begin
                    send_byte(8'h80 | 8'($urandom_range(0, 8'h3F)));
                    sent++;
                end
                if (r >= 80 && len > 1) begin
                    b = 8'($urandom_range(0, 255));
                    if (b[7:6] == 2'b10)
                        b = b ^ 8'h40;
                    send_byte(b);
                    sent++;
                end
            end
        end
    endtask

    initial begin : sink
        int r;
        int stall_left;
        int free_left;
        bit hold_done;
        stall_left = 0;
        free_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req && !hold_done) begin
                hold_done     = 1'b1;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else if (free_left > 0) begin
                m_axis_tready = 1'b1;
                free_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    m_axis_tready = 1'b1;
                    free_left = $urandom_range(30, 120);
                end else if (r < 75) begin
                    m_axis_tready = 1'b1;
                end else if (r < 97) begin
                    m_axis_tready = 1'b0;
                end else begin
                    m_axis_tready = 1'b0;
                    stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    initial begin : stimulus
        logic [7:0] directed_bytes[$];
        bit decoding;
        directed_bytes = '{8'h00, 8'h7F, 8'hC2, 8'hA9, 8'hDF, 8'hBF, 8'hE2, 8'h82, 8'hAC,
                           8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                           8'h80, 8'hBF, 8'hF8, 8'hFF, 8'hC3, 8'h41, 8'hE2, 8'h82, 8'hC3};
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_bytes[k])
            send_byte(directed_bytes[k]);
        // open sequence dropped by pass-through; its tail is then stray
        send_byte(8'hE2);
        send_byte(8'h82);
        write_decode_enable(1'b0);
        send_byte(8'h41);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h00);
        write_decode_enable(1'b1);
        send_byte(8'h82);
        // rewriting the mode mid-sequence keeps the sequence
        send_byte(8'hC3);
        write_decode_enable(1'b1);
        send_byte(8'hA9);

        for (int p = 0; p < 8; p++) begin
            decoding = (p % 3 != 1);
            write_decode_enable(decoding);
            sender_gaps_on = (p % 4 != 2);
            if (p == 3) begin
                // fill the block while the output is blocked
                sink_hold_req = 1'b1;
                repeat (48) send_byte(8'($urandom_range(8'h00, 8'h7F)));
            end
            send_random_text(190, decoding);
        end

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
